// ----- hw/rtl/convex_polyhedron_interior_test_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the convex polyhedron interior test
// Concurrent checks sampled on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef CONVEX_POLYHEDRON_INTERIOR_TEST_ASSERT_SVH
`define CONVEX_POLYHEDRON_INTERIOR_TEST_ASSERT_SVH

// Same-cycle implication
`define CPI_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpi check failed");

// Next-cycle implication
`define CPI_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpi check failed");

`endif

// ----- hw/rtl/cpi_pkg.sv -----
// ----------------------------------------------------------------------------
// cpi_pkg
// Types, constants and codes shared by the convex polyhedron interior test.
// ----------------------------------------------------------------------------
`default_nettype none

package cpi_pkg;

  localparam int COORD_W        = 32;
  localparam int CPI_MAX_PLANES = 64;
  localparam int LEN_W          = 32;
  localparam int SQ_W           = 64;
  localparam int DOT_W          = 64;
  localparam int RTOL_W         = 16;
  localparam int ATOL_W         = 31;
  localparam int TOL_W          = LEN_W + RTOL_W + 1;
  localparam int PIDX_W         = 16;
  localparam int CFG_W          = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int MUL_A_W        = COORD_W;
  localparam int MUL_B_W        = COORD_W + 1;
  localparam int MUL_STEP_W     = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INSIDE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INSIDE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INSIDE_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REL_TOL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ABS_TOL  = 3'd4;

  // Item kinds
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_TEST  = 2'd2;

  typedef struct packed {
    logic [1:0]                 kind;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic signed [COORD_W-1:0]  pos_z;
    logic signed [COORD_W-1:0]  norm_x;
    logic signed [COORD_W-1:0]  norm_y;
    logic signed [COORD_W-1:0]  norm_z;
  } in_word_t;

  typedef struct packed {
    logic [PIDX_W-1:0] point_index;
    logic              is_inside;
  } out_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] norm_x;
    logic signed [COORD_W-1:0] norm_y;
    logic signed [COORD_W-1:0] norm_z;
    logic signed [COORD_W-1:0] off_x;
    logic signed [COORD_W-1:0] off_y;
    logic signed [COORD_W-1:0] off_z;
    logic [LEN_W-1:0]          len;
  } plane_t;

  typedef enum logic [1:0] {AX_X, AX_Y, AX_Z} axis_t;

  typedef enum logic {MUL_SQ, MUL_DOT} mul_op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SQ_GO, S_SQ_WAIT, S_ROOT_GO, S_ROOT_WAIT,
    S_RD, S_TOL, S_DOT_GO, S_DOT_WAIT, S_CMP, S_RESULT
  } ctrl_state_t;

  typedef struct packed {
    logic    capture;
    logic    clear;
    logic    mul_start;
    mul_op_t op;
    axis_t   axis;
    logic    acc_sq;
    logic    root_start;
    logic    plane_wr;
    logic    dlen_ld;
    logic    scan_init;
    logic    rd_en;
    logic    tol_ld;
    logic    acc_dot;
    logic    cmp;
    logic    idx_inc;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       full;
    logic       empty;
    logic       mul_done;
    logic       root_done;
    logic       dot_gt;
    logic       idx_last;
    logic       out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cpi_mul.sv -----
// ----------------------------------------------------------------------------
// cpi_mul
// Unsigned multiplier, one STEP_W-bit digit of b per cycle, top digit first.
// ----------------------------------------------------------------------------
`default_nettype none

module cpi_mul
  import cpi_pkg::*;
#(
  parameter int A_W    = MUL_A_W,
  parameter int B_W    = MUL_B_W,
  parameter int STEP_W = MUL_STEP_W
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [A_W-1:0]       a,
  input  wire logic [B_W-1:0]       b,
  output logic                      busy,
  output logic                      done,
  output logic [A_W+((B_W+STEP_W-1)/STEP_W)*STEP_W-1:0] prod
);

  localparam int STEPS = (B_W + STEP_W - 1) / STEP_W;
  localparam int BP_W  = STEPS * STEP_W;
  localparam int P_W   = A_W + BP_W;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [A_W-1:0]        a_r;
  logic [BP_W-1:0]       b_r;
  logic [P_W-1:0]        acc;
  logic [CNT_W-1:0]      cnt;
  logic [A_W+STEP_W-1:0] part;

  // One partial product per cycle
  assign part = {{STEP_W{1'b0}}, a_r} * {{A_W{1'b0}}, b_r[BP_W-1 -: STEP_W]};

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operands and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= BP_W'(b);
      acc <= '0;
    end else if (busy) begin
      acc <= (acc << STEP_W) + P_W'(part);
      b_r <= b_r << STEP_W;
    end
  end

  assign prod = acc;

endmodule

`default_nettype wire

// ----- hw/rtl/cpi_sqrt.sv -----
// ----------------------------------------------------------------------------
// cpi_sqrt
// Integer square root, floor(sqrt(v)), one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cpi_sqrt
  import cpi_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [SQ_W-1:0]  v,
  output logic                  done,
  output logic [LEN_W-1:0]      root
);

  logic            busy;
  logic [SQ_W-1:0] rem;
  logic [SQ_W-1:0] res;
  logic [SQ_W-1:0] bitm;
  logic [SQ_W:0]   trial;
  logic            ge;

  assign trial = {1'b0, res} + {1'b0, bitm};
  assign ge    = ({1'b0, rem} >= trial);

  // Iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitm[1:0] == 2'b01 && bitm[SQ_W-1:2] == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Restoring root step
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= v;
      res  <= '0;
      bitm <= {2'b01, {(SQ_W-2){1'b0}}};
    end else if (busy) begin
      if (ge) begin
        rem <= rem - trial[SQ_W-1:0];
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

  assign root = res[LEN_W-1:0];

endmodule

`default_nettype wire

// ----- hw/rtl/cpi_datapath.sv -----
// ----------------------------------------------------------------------------
// cpi_datapath
// Config registers, offsets, plane table, shared multiplier and root unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "convex_polyhedron_interior_test_assert.svh"

module cpi_datapath
  import cpi_pkg::*;
#(
  parameter int MAX_PLANES = CPI_MAX_PLANES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire in_word_t              in_word,
  output out_word_t                  out_word,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  input  wire cmd_t                  cmd,
  output status_t                    st
);

  localparam int PI_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int PC_W = $clog2(MAX_PLANES + 1);
  localparam int P_W  = MUL_A_W + ((MUL_B_W + MUL_STEP_W - 1) / MUL_STEP_W) * MUL_STEP_W;
  localparam logic signed [DOT_W-1:0] DOT_MAX = {1'b0, {(DOT_W-1){1'b1}}};
  localparam logic signed [DOT_W-1:0] DOT_MIN = -DOT_MAX;

  // Clamp p - c to the signed coordinate range
  function automatic logic signed [COORD_W-1:0] sat_diff(
    input logic signed [COORD_W-1:0] p,
    input logic signed [COORD_W-1:0] c
  );
    logic signed [COORD_W:0] diff;
    diff = {p[COORD_W-1], p} - {c[COORD_W-1], c};
    if (diff[COORD_W] != diff[COORD_W-1]) begin
      sat_diff = diff[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      sat_diff = diff[COORD_W-1:0];
    end
  endfunction

  logic signed [COORD_W-1:0] inside_x, inside_y, inside_z;
  logic [RTOL_W-1:0]         rel_tol;
  logic [ATOL_W-1:0]         abs_tol;

  logic [1:0]                kind;
  logic signed [COORD_W-1:0] nx, ny, nz;
  logic signed [COORD_W-1:0] dx, dy, dz;
  logic [LEN_W-1:0]          dlen;
  logic [SQ_W-1:0]           sq_sum;
  logic signed [DOT_W-1:0]   dot_acc;
  logic [TOL_W-1:0]          tol;
  logic [PC_W-1:0]           plane_count;
  logic [PI_W-1:0]           idx;
  logic                      inside_flag;
  logic [PIDX_W-1:0]         tested;
  logic                      neg;

  plane_t                    mem [MAX_PLANES];
  plane_t                    rd_plane;

  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic                      mul_neg;
  logic                      mul_busy;
  logic                      mul_done;
  logic [P_W-1:0]            prod;
  logic                      root_done;
  logic [LEN_W-1:0]          root;

  logic signed [COORD_W-1:0] d_sel, n_sel, o_sel;
  logic signed [COORD_W:0]   rel;
  logic [SQ_W-1:0]           sq_term;
  logic [SQ_W:0]             sq_add;
  logic [DOT_W-1:0]          p_mag;
  logic signed [DOT_W-1:0]   dot_term;
  logic signed [DOT_W:0]     dot_add;
  logic [LEN_W-1:0]          len_max;
  logic [LEN_W+RTOL_W-1:0]   tol_prod;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_x <= '0;
      inside_y <= '0;
      inside_z <= '0;
      rel_tol  <= '0;
      abs_tol  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INSIDE_X: inside_x <= cfg_data[COORD_W-1:0];
        CFG_INSIDE_Y: inside_y <= cfg_data[COORD_W-1:0];
        CFG_INSIDE_Z: inside_z <= cfg_data[COORD_W-1:0];
        CFG_REL_TOL:  rel_tol  <= cfg_data[RTOL_W-1:0];
        CFG_ABS_TOL:  abs_tol  <= cfg_data[ATOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Select multiplier operands by axis
  always_comb begin
    case (cmd.axis)
      AX_X: begin
        d_sel = dx; n_sel = rd_plane.norm_x; o_sel = rd_plane.off_x;
      end
      AX_Y: begin
        d_sel = dy; n_sel = rd_plane.norm_y; o_sel = rd_plane.off_y;
      end
      AX_Z: begin
        d_sel = dz; n_sel = rd_plane.norm_z; o_sel = rd_plane.off_z;
      end
      default: begin
        d_sel = dx; n_sel = rd_plane.norm_x; o_sel = rd_plane.off_x;
      end
    endcase
    rel = {d_sel[COORD_W-1], d_sel} - {o_sel[COORD_W-1], o_sel};
    if (cmd.op == MUL_SQ) begin
      mul_a   = d_sel[COORD_W-1] ? MUL_A_W'(~d_sel + 1'b1) : MUL_A_W'(d_sel);
      mul_b   = MUL_B_W'(mul_a);
      mul_neg = 1'b0;
    end else begin
      mul_a   = n_sel[COORD_W-1] ? MUL_A_W'(~n_sel + 1'b1) : MUL_A_W'(n_sel);
      mul_b   = rel[COORD_W] ? MUL_B_W'(~rel + 1'b1) : MUL_B_W'(rel);
      mul_neg = n_sel[COORD_W-1] ^ rel[COORD_W];
    end
  end

  cpi_mul #(
    .A_W    (MUL_A_W),
    .B_W    (MUL_B_W),
    .STEP_W (MUL_STEP_W)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (prod)
  );

  cpi_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.root_start),
    .v     (sq_sum),
    .done  (root_done),
    .root  (root)
  );

  // Saturating sum of squares and signed dot accumulation
  always_comb begin
    sq_term  = (|prod[P_W-1:SQ_W]) ? {SQ_W{1'b1}} : prod[SQ_W-1:0];
    sq_add   = {1'b0, sq_sum} + {1'b0, sq_term};
    p_mag    = (|prod[P_W-1:DOT_W-1]) ? DOT_MAX : {1'b0, prod[DOT_W-2:0]};
    dot_term = neg ? -$signed(p_mag) : $signed(p_mag);
    dot_add  = {dot_acc[DOT_W-1], dot_acc} + {dot_term[DOT_W-1], dot_term};
    len_max  = (dlen > rd_plane.len) ? dlen : rd_plane.len;
    tol_prod = (LEN_W+RTOL_W)'(len_max) * (LEN_W+RTOL_W)'(rel_tol);
  end

  // Item registers and arithmetic state
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind   <= in_word.kind;
      nx     <= in_word.norm_x;
      ny     <= in_word.norm_y;
      nz     <= in_word.norm_z;
      dx     <= sat_diff(in_word.pos_x, inside_x);
      dy     <= sat_diff(in_word.pos_y, inside_y);
      dz     <= sat_diff(in_word.pos_z, inside_z);
      sq_sum <= '0;
    end
    if (cmd.mul_start) begin
      neg <= mul_neg;
    end
    if (cmd.acc_sq) begin
      sq_sum <= sq_add[SQ_W] ? {SQ_W{1'b1}} : sq_add[SQ_W-1:0];
    end
    if (cmd.dlen_ld) begin
      dlen <= root;
    end
    if (cmd.tol_ld) begin
      tol     <= TOL_W'(tol_prod) + TOL_W'({abs_tol, 16'b0});
      dot_acc <= '0;
    end
    if (cmd.acc_dot) begin
      if (dot_add > $signed({DOT_MAX[DOT_W-1], DOT_MAX})) begin
        dot_acc <= DOT_MAX;
      end else if (dot_add < $signed({DOT_MIN[DOT_W-1], DOT_MIN})) begin
        dot_acc <= DOT_MIN;
      end else begin
        dot_acc <= dot_add[DOT_W-1:0];
      end
    end
  end

  // Plane table
  always_ff @(posedge clk) begin
    if (cmd.plane_wr) begin
      mem[plane_count[PI_W-1:0]] <= '{norm_x: nx, norm_y: ny, norm_z: nz,
                                      off_x: dx, off_y: dy, off_z: dz, len: root};
    end
    if (cmd.rd_en) begin
      rd_plane <= mem[idx];
    end
  end

  // Counters, scan index and verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      plane_count <= '0;
      tested      <= '0;
      idx         <= '0;
      inside_flag <= 1'b1;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.clear) begin
        plane_count <= '0;
      end else if (cmd.plane_wr) begin
        plane_count <= plane_count + 1'b1;
      end
      if (cmd.scan_init) begin
        idx         <= '0;
        inside_flag <= 1'b1;
      end else if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (cmd.cmp && st.dot_gt) begin
        inside_flag <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
        tested    <= tested + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output word
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word.point_index <= tested;
      out_word.is_inside   <= inside_flag;
    end
  end

  // Status to the controller
  assign st.kind      = kind;
  assign st.full      = (plane_count >= PC_W'(MAX_PLANES));
  assign st.empty     = (plane_count == '0);
  assign st.mul_done  = mul_done;
  assign st.root_done = root_done;
  assign st.dot_gt    = (dot_acc > $signed(DOT_W'(tol)));
  assign st.idx_last  = (PC_W'(idx) == plane_count - 1'b1);
  assign st.out_free  = !out_valid || out_ready;

  `CPI_ASSERT_IMPL(a_count_bound, 1'b1, plane_count <= PC_W'(MAX_PLANES))
  `CPI_ASSERT_IMPL(a_wr_not_full, cmd.plane_wr, plane_count < PC_W'(MAX_PLANES))
  `CPI_ASSERT_IMPL(a_out_free, cmd.out_load, !out_valid || out_ready)
  `CPI_ASSERT_IMPL(a_mul_idle, cmd.mul_start, !mul_busy)
  `CPI_ASSERT_NEXT(a_index_step, cmd.out_load, tested == $past(tested) + 1'b1)

endmodule

`default_nettype wire

// ----- hw/rtl/cpi_ctrl.sv -----
// ----------------------------------------------------------------------------
// cpi_ctrl
// Sequencer: length of the offset, then a table write (load) or one pass over the stored planes (test).
// ----------------------------------------------------------------------------
`default_nettype none

module cpi_ctrl
  import cpi_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output cmd_t         cmd,
  input  wire status_t st
);

  ctrl_state_t state, state_next;
  axis_t       axis, axis_next;

  function automatic axis_t axis_step(input axis_t a);
    case (a)
      AX_X:    axis_step = AX_Y;
      AX_Y:    axis_step = AX_Z;
      default: axis_step = AX_X;
    endcase
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= AX_X;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    axis_next  = axis;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        axis_next = AX_X;
        case (st.kind)
          KIND_LOAD: state_next = st.full ? S_IDLE : S_SQ_GO;
          KIND_TEST: state_next = S_SQ_GO;
          default:   state_next = S_IDLE;
        endcase
      end
      S_SQ_GO: state_next = S_SQ_WAIT;
      S_SQ_WAIT: begin
        if (st.mul_done) begin
          axis_next  = axis_step(axis);
          state_next = (axis == AX_Z) ? S_ROOT_GO : S_SQ_GO;
        end
      end
      S_ROOT_GO: state_next = S_ROOT_WAIT;
      S_ROOT_WAIT: begin
        if (st.root_done) begin
          if (st.kind == KIND_LOAD) begin
            state_next = S_IDLE;
          end else begin
            state_next = st.empty ? S_RESULT : S_RD;
          end
        end
      end
      S_RD: state_next = S_TOL;
      S_TOL: begin
        axis_next  = AX_X;
        state_next = S_DOT_GO;
      end
      S_DOT_GO: state_next = S_DOT_WAIT;
      S_DOT_WAIT: begin
        if (st.mul_done) begin
          axis_next  = axis_step(axis);
          state_next = (axis == AX_Z) ? S_CMP : S_DOT_GO;
        end
      end
      S_CMP: state_next = (st.dot_gt || st.idx_last) ? S_RESULT : S_RD;
      S_RESULT: begin
        if (st.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    cmd.axis = axis;
    cmd.op   = MUL_SQ;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_DECODE: cmd.clear = (st.kind == KIND_CLEAR);
      S_SQ_GO: cmd.mul_start = 1'b1;
      S_SQ_WAIT: cmd.acc_sq = st.mul_done;
      S_ROOT_GO: cmd.root_start = 1'b1;
      S_ROOT_WAIT: begin
        if (st.root_done) begin
          if (st.kind == KIND_LOAD) begin
            cmd.plane_wr = 1'b1;
          end else begin
            cmd.dlen_ld   = 1'b1;
            cmd.scan_init = 1'b1;
          end
        end
      end
      S_RD: cmd.rd_en = 1'b1;
      S_TOL: cmd.tol_ld = 1'b1;
      S_DOT_GO: begin
        cmd.op        = MUL_DOT;
        cmd.mul_start = 1'b1;
      end
      S_DOT_WAIT: begin
        cmd.op      = MUL_DOT;
        cmd.acc_dot = st.mul_done;
      end
      S_CMP: begin
        cmd.cmp     = 1'b1;
        cmd.idx_inc = !st.dot_gt && !st.idx_last;
      end
      S_RESULT: cmd.out_load = st.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/convex_polyhedron_interior_test.sv -----
// Sequence: a clear is captured and decoded; a load takes three squares on the
// shared multiplier, a 32-step root and a table write. A test takes the squares
// and root, then per stored plane a table read, tolerance and three 3-digit
// products. One item at a time; the shared multiplier and root unit set the
// rate. Reset (rst, synchronous) empties the plane table, zeroes the point
// index and the config registers; table contents stay undefined until loaded.
// ----------------------------------------------------------------------------
// convex_polyhedron_interior_test
// Tests points against a table of bounding planes, one verdict out per test word.
// ----------------------------------------------------------------------------
`default_nettype none

module convex_polyhedron_interior_test
  import cpi_pkg::*;
#(
  parameter int MAX_PLANES = CPI_MAX_PLANES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_word_t              in_word,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_word_t                  out_word
);

  cmd_t    cmd;
  status_t st;

  cpi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .st       (st)
  );

  cpi_datapath #(
    .MAX_PLANES (MAX_PLANES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .out_word  (out_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

`default_nettype wire
